// ===== rtl/sfe_pkg.sv =====
// Shared constants, types and register codes of the SBUS frame encoder.
package sfe_pkg;

	localparam int NumRaw    = 10;              // raw channels per item
	localparam int NumCh     = 16;              // channels per frame
	localparam int ChW       = 11;              // channel width
	localparam int ByteW     = 8;
	localparam int FrameLen  = 25;
	localparam int RawIdxW   = $clog2(NumRaw + 1);
	localparam int ByteCntW  = $clog2(FrameLen);
	localparam int ProdW     = ByteW + ChW + 2; // signed raw times signed span
	localparam int MagW      = ByteW + ChW;     // |raw * span| < 2^MagW
	localparam int CfgIdxW   = 3;
	localparam int CfgDataW  = ChW;
	localparam int QDepth    = 2;
	localparam int QPtrW     = $clog2(QDepth);
	localparam int QCntW     = $clog2(QDepth + 1);
	localparam int RawFull   = 255;

	localparam logic [ByteCntW-1:0] HeaderIdx = ByteCntW'(0);
	localparam logic [ByteCntW-1:0] FlagIdx   = ByteCntW'(FrameLen - 2);
	localparam logic [ByteCntW-1:0] FooterIdx = ByteCntW'(FrameLen - 1);

	localparam logic [ByteW-1:0] FlagFrameLost = ByteW'(1 << 2);
	localparam logic [ByteW-1:0] FlagFailsafe  = ByteW'(1 << 3);

	localparam logic [ChW-1:0]   MinRst    = ChW'(172);
	localparam logic [ChW-1:0]   MaxRst    = ChW'(1811);
	localparam logic [ChW-1:0]   MidRst    = ChW'(992);
	localparam logic [ByteW-1:0] HeaderRst = ByteW'(15);
	localparam logic [ByteW-1:0] FooterRst = ByteW'(0);

	typedef enum logic [CfgIdxW-1:0] {
		REG_MIN    = 3'd0,
		REG_MAX    = 3'd1,
		REG_MID    = 3'd2,
		REG_HEADER = 3'd3,
		REG_FOOTER = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [ChW-1:0]   scaled_min;
		logic [ChW-1:0]   scaled_max;
		logic [ChW-1:0]   scaled_mid;
		logic [ByteW-1:0] header_byte;
		logic [ByteW-1:0] footer_byte;
	} sfe_cfg_t;

	// Channel k sits at bits 11k..11k+10: the packed order is the wire order.
	typedef struct packed {
		logic                      lost;
		logic [NumCh-1:0][ChW-1:0] ch;
	} sfe_item_t;

endpackage

// ===== rtl/sfe_if.sv =====
// Handshake interfaces of the SBUS frame encoder: input items, frame bytes, config writes.
interface sfe_cmd_if;
	import sfe_pkg::*;
	logic             valid;
	logic             ready;
	logic [ByteW-1:0] channel_1;
	logic [ByteW-1:0] channel_2;
	logic [ByteW-1:0] channel_3;
	logic [ByteW-1:0] channel_4;
	logic [ByteW-1:0] channel_5;
	logic [ByteW-1:0] channel_6;
	logic [ByteW-1:0] channel_7;
	logic [ByteW-1:0] channel_8;
	logic [ByteW-1:0] channel_9;
	logic [ByteW-1:0] channel_10;
	logic             link_lost;
	modport source (output valid, channel_1, channel_2, channel_3, channel_4, channel_5,
		channel_6, channel_7, channel_8, channel_9, channel_10, link_lost, input ready);
	modport sink (input valid, channel_1, channel_2, channel_3, channel_4, channel_5,
		channel_6, channel_7, channel_8, channel_9, channel_10, link_lost, output ready);
endinterface

interface sfe_frame_if;
	import sfe_pkg::*;
	logic             valid;
	logic             ready;
	logic [ByteW-1:0] frame_byte;
	logic             last_byte;
	modport source (output valid, frame_byte, last_byte, input ready);
	modport sink (input valid, frame_byte, last_byte, output ready);
endinterface

interface sfe_cfg_if;
	import sfe_pkg::*;
	logic                valid;
	logic                ready;
	logic [CfgIdxW-1:0]  index;
	logic [CfgDataW-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/sfe_front.sv =====
// Front end: takes an item, scales the raw channels through a shared 3-stage unit.
module sfe_front (
	input  logic                 clk,
	input  logic                 arst_n,
	sfe_cmd_if.sink              cmd,
	input  sfe_pkg::sfe_cfg_t    cfg,
	output logic                 push_valid,
	input  logic                 push_ready,
	output sfe_pkg::sfe_item_t   push_item
);
	import sfe_pkg::*;

	logic                           busy_q;
	logic                           pend_q;
	logic [RawIdxW-1:0]             iss_q;
	logic                           lost_q;
	logic [NumRaw-1:0][ByteW-1:0]   raw_q;
	logic [NumRaw-1:0][ChW-1:0]     ch_q;
	logic [NumRaw-1:0][ByteW-1:0]   cmd_raw;

	logic                           v_s1;
	logic [RawIdxW-1:0]             idx_s1;
	logic signed [ProdW-1:0]        p_s1;
	logic                           v_s2;
	logic [RawIdxW-1:0]             idx_s2;
	logic                           neg_s2;
	logic [MagW-1:0]                m_s2;
	logic [ChW-1:0]                 qe_s2;

	logic                           accept;
	logic                           issue;
	logic signed [ByteW:0]          xs_w;
	logic signed [ChW:0]            span_w;
	logic signed [ProdW-1:0]        prod_w;
	logic [ProdW-1:0]               mag_w;
	logic [MagW+ByteW-1:0]          est_w;
	logic [MagW-1:0]                qmul_w;
	logic [MagW-1:0]                rem_w;
	logic [ChW-1:0]                 q_w;
	logic [ChW-1:0]                 val_w;

	assign cmd_raw[0] = cmd.channel_1;
	assign cmd_raw[1] = cmd.channel_2;
	assign cmd_raw[2] = cmd.channel_3;
	assign cmd_raw[3] = cmd.channel_4;
	assign cmd_raw[4] = cmd.channel_5;
	assign cmd_raw[5] = cmd.channel_6;
	assign cmd_raw[6] = cmd.channel_7;
	assign cmd_raw[7] = cmd.channel_8;
	assign cmd_raw[8] = cmd.channel_9;
	assign cmd_raw[9] = cmd.channel_10;

	assign cmd.ready = !busy_q;
	assign accept    = cmd.valid && !busy_q;
	assign issue     = busy_q && (iss_q < RawIdxW'(NumRaw));

	// stage 1: signed raw * span
	always_comb begin
		xs_w   = $signed({1'b0, raw_q[iss_q]});
		span_w = $signed({1'b0, cfg.scaled_max}) - $signed({1'b0, cfg.scaled_min});
		prod_w = xs_w * span_w;
	end

	// stage 2: magnitude, quotient estimate m*257 >> 16 (low by at most one)
	always_comb begin
		mag_w = p_s1[ProdW-1] ? ProdW'(-p_s1) : ProdW'(p_s1);
		est_w = {ByteW'(0), mag_w[MagW-1:0]} + {mag_w[MagW-1:0], ByteW'(0)};
	end

	// stage 3: one correction step, then apply sign around scaled_min
	always_comb begin
		qmul_w = {qe_s2, ByteW'(0)} - MagW'(qe_s2);
		rem_w  = m_s2 - qmul_w;
		q_w    = qe_s2 + ChW'(rem_w >= MagW'(RawFull));
		val_w  = neg_s2 ? (cfg.scaled_min - q_w) : (cfg.scaled_min + q_w);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pend_q <= 1'b0;
			iss_q  <= '0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (accept) begin
				busy_q <= 1'b1;
				iss_q  <= '0;
			end else if (issue) begin
				iss_q <= iss_q + RawIdxW'(1);
			end
			if (v_s2 && idx_s2 == RawIdxW'(NumRaw - 1))
				pend_q <= 1'b1;
			if (pend_q && push_ready) begin
				pend_q <= 1'b0;
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			raw_q  <= cmd_raw;
			lost_q <= cmd.link_lost;
		end
		idx_s1 <= iss_q;
		p_s1   <= prod_w;
		idx_s2 <= idx_s1;
		neg_s2 <= p_s1[ProdW-1];
		m_s2   <= mag_w[MagW-1:0];
		qe_s2  <= est_w[2*ByteW +: ChW];
		if (v_s2)
			ch_q[idx_s2] <= val_w;
	end

	assign push_valid = pend_q;

	always_comb begin
		push_item.lost = lost_q;
		for (int k = 0; k < NumCh; k++) begin
			if (k < NumRaw && !lost_q)
				push_item.ch[k] = ch_q[k];
			else
				push_item.ch[k] = cfg.scaled_mid;
		end
	end

endmodule

// ===== rtl/sfe_queue.sv =====
// Two-entry queue of scaled items between front and back end.
module sfe_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	output logic                 push_ready,
	input  sfe_pkg::sfe_item_t   push_item,
	output logic                 pop_valid,
	input  logic                 pop_ready,
	output sfe_pkg::sfe_item_t   pop_item
);
	import sfe_pkg::*;

	sfe_item_t          mem_q [QDepth];
	logic [QPtrW-1:0]   wr_q;
	logic [QPtrW-1:0]   rd_q;
	logic [QCntW-1:0]   cnt_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = cnt_q != QCntW'(QDepth);
	assign pop_valid  = cnt_q != '0;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_item   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= wr_q + QPtrW'(1);
			if (do_pop)
				rd_q <= rd_q + QPtrW'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + QCntW'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - QCntW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= push_item;
	end

endmodule

// ===== rtl/sfe_back.sv =====
// Back end: serializes one queued item into a 25-byte frame through an output register.
module sfe_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sfe_pkg::sfe_cfg_t    cfg,
	input  logic                 pop_valid,
	output logic                 pop_ready,
	input  sfe_pkg::sfe_item_t   pop_item,
	sfe_frame_if.source          frame
);
	import sfe_pkg::*;

	logic                        active_q;
	logic [ByteCntW-1:0]         cnt_q;
	logic [NumCh*ChW-1:0]        sh_q;
	logic                        lost_q;
	logic                        ovalid_q;
	logic [ByteW-1:0]            byte_q;
	logic                        last_q;
	logic                        advance;
	logic                        emit;
	logic                        load;

	assign advance   = !ovalid_q || frame.ready;
	assign emit      = advance && active_q;
	// refill on the footer so frames run back to back
	assign pop_ready = !active_q || (emit && cnt_q == FooterIdx);
	assign load      = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (advance)
				ovalid_q <= active_q;
			if (load) begin
				active_q <= 1'b1;
				cnt_q    <= HeaderIdx;
			end else if (emit) begin
				cnt_q <= cnt_q + ByteCntW'(1);
				if (cnt_q == FooterIdx)
					active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			last_q <= 1'b0;
			unique case (cnt_q)
				HeaderIdx: byte_q <= cfg.header_byte;
				FlagIdx:   byte_q <= lost_q ? (FlagFrameLost | FlagFailsafe) : '0;
				FooterIdx: begin
					byte_q <= cfg.footer_byte;
					last_q <= 1'b1;
				end
				default:   byte_q <= sh_q[ByteW-1:0];
			endcase
		end
		if (load) begin
			sh_q   <= pop_item.ch;
			lost_q <= pop_item.lost;
		end else if (emit && cnt_q != HeaderIdx && cnt_q != FlagIdx && cnt_q != FooterIdx) begin
			sh_q <= sh_q >> ByteW;
		end
	end

	assign frame.valid      = ovalid_q;
	assign frame.frame_byte = byte_q;
	assign frame.last_byte  = last_q;

`ifndef ASSERT_OFF
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> cnt_q <= FooterIdx)
		else $error("byte counter out of frame");
	a_footer_last: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && cnt_q == FooterIdx) |=> (ovalid_q && last_q))
		else $error("footer not marked last");
	a_load_start: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (active_q && cnt_q == HeaderIdx))
		else $error("loaded item does not start at header");
	// an idle serializer may still load the next item while its last byte waits
	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(active_q && ovalid_q && !frame.ready) |=> (cnt_q == $past(cnt_q)))
		else $error("frame advanced during output stall");
`endif

endmodule

// ===== rtl/sbus_frame_encoder.sv =====
// SBUS frame encoder top level: configuration registers, front end, queue, back end.
// Throughput: one frame byte per cycle while the byte output is not stalled; the back end
// byte serializer sets this, the front scales its ten channels in turn.
// Back pressure on the byte output stalls the serializer; the queue holds two items.
// Reset (arst_n low, asynchronous) empties the pipeline and loads register defaults.
module sbus_frame_encoder (
	input  logic        clk,
	input  logic        arst_n,
	sfe_cmd_if.sink     cmd,
	sfe_frame_if.source frame,
	sfe_cfg_if.sink     cfg
);
	import sfe_pkg::*;

	sfe_cfg_t   cfg_q;
	logic       push_valid;
	logic       push_ready;
	sfe_item_t  push_item;
	logic       pop_valid;
	logic       pop_ready;
	sfe_item_t  pop_item;

	// config writes are always taken; unknown indexes fall through
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scaled_min  <= MinRst;
			cfg_q.scaled_max  <= MaxRst;
			cfg_q.scaled_mid  <= MidRst;
			cfg_q.header_byte <= HeaderRst;
			cfg_q.footer_byte <= FooterRst;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_MIN:    cfg_q.scaled_min  <= cfg.data[ChW-1:0];
				REG_MAX:    cfg_q.scaled_max  <= cfg.data[ChW-1:0];
				REG_MID:    cfg_q.scaled_mid  <= cfg.data[ChW-1:0];
				REG_HEADER: cfg_q.header_byte <= cfg.data[ByteW-1:0];
				REG_FOOTER: cfg_q.footer_byte <= cfg.data[ByteW-1:0];
				default:    ;
			endcase
		end
	end

	// front: latch item, scale channels 1..10 one per cycle, fill the rest (all of them when the link is lost) with mid
	sfe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg        (cfg_q),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	// decouples scaling from byte output
	sfe_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	// back: header, 22 packed channel bytes, flags, footer
	sfe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item),
		.frame     (frame)
	);

endmodule

// ===== dv/sbus_frame_encoder_checker.sv =====
// Passive checker for the SBUS frame encoder: tracks registers, predicts frame bytes, compares.
module sbus_frame_encoder_checker (
	input  logic clk,
	input  logic arst_n,
	sfe_cmd_if   cmd,
	sfe_frame_if frame,
	sfe_cfg_if   cfg,
	output int   fails,
	output int   bytes_pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import sfe_pkg::*;

	typedef struct {
		logic [ByteW-1:0] data;
		logic             last;
		int               frame_no;
		int               pos;
	} frame_byte_t;

	frame_byte_t frame_bytes_due[$];
	sfe_cfg_t    regs;
	int          frames_queued;

	task automatic report_mismatch(input string what);
		$display("[%0t] MISMATCH %s", $time, what);
		fails = fails + 1;
	endtask

	// Signed scaling; the quotient truncates toward zero, so max below min runs downward.
	function automatic logic [ChW-1:0] scale_stick(input logic [ByteW-1:0] raw,
		input sfe_cfg_t c);
		int lo;
		int span;
		int v;
		lo   = int'(c.scaled_min);
		span = int'(c.scaled_max) - lo;
		v    = lo + (int'(raw) * span) / RawFull;
		return v[ChW-1:0];
	endfunction

	// Builds the 25 bytes of one frame from the current registers.
	task automatic queue_frame_bytes(input logic [NumRaw-1:0][ByteW-1:0] raw,
		input logic lost);
		logic [NumCh*ChW-1:0] bits;
		frame_byte_t          b;
		for (int k = 0; k < NumCh; k++) begin
			if (!lost && k < NumRaw)
				bits[k*ChW +: ChW] = scale_stick(raw[k], regs);
			else
				bits[k*ChW +: ChW] = regs.scaled_mid;
		end
		b.frame_no = frames_queued;
		b.last     = 1'b0;
		b.pos      = 0;
		b.data     = regs.header_byte;
		frame_bytes_due.push_back(b);
		for (int i = 0; i < NumCh * ChW / ByteW; i++) begin
			b.pos  = i + 1;
			b.data = bits[i*ByteW +: ByteW];
			frame_bytes_due.push_back(b);
		end
		b.pos  = FrameLen - 2;
		b.data = lost ? (FlagFrameLost | FlagFailsafe) : '0;
		frame_bytes_due.push_back(b);
		b.pos  = FrameLen - 1;
		b.data = regs.footer_byte;
		b.last = 1'b1;
		frame_bytes_due.push_back(b);
		frames_queued++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		frame_byte_t want;
		if (!arst_n) begin
			regs.scaled_min  <= MinRst;
			regs.scaled_max  <= MaxRst;
			regs.scaled_mid  <= MidRst;
			regs.header_byte <= HeaderRst;
			regs.footer_byte <= FooterRst;
			frame_bytes_due.delete();
			bytes_pending <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_MIN:    regs.scaled_min  <= cfg.data;
					REG_MAX:    regs.scaled_max  <= cfg.data;
					REG_MID:    regs.scaled_mid  <= cfg.data;
					REG_HEADER: regs.header_byte <= cfg.data[ByteW-1:0];
					REG_FOOTER: regs.footer_byte <= cfg.data[ByteW-1:0];
					default: ; // unmapped index, dropped
				endcase
			end
			if (cmd.valid && cmd.ready)
				queue_frame_bytes({cmd.channel_10, cmd.channel_9, cmd.channel_8, cmd.channel_7,
					cmd.channel_6, cmd.channel_5, cmd.channel_4, cmd.channel_3, cmd.channel_2,
					cmd.channel_1}, cmd.link_lost);
			if (frame.valid && frame.ready) begin
				if (frame_bytes_due.size() == 0) begin
					report_mismatch($sformatf("unexpected frame byte %02h", frame.frame_byte));
				end else begin
					want = frame_bytes_due.pop_front();
					if (frame.frame_byte !== want.data)
						report_mismatch($sformatf("frame %0d byte %0d: frame_byte %02h, want %02h",
							want.frame_no, want.pos, frame.frame_byte, want.data));
					if (frame.last_byte !== want.last)
						report_mismatch($sformatf("frame %0d byte %0d: last_byte %b, want %b",
							want.frame_no, want.pos, frame.last_byte, want.last));
				end
			end
			bytes_pending <= frame_bytes_due.size();
		end
	end

endmodule

// ===== dv/sbus_frame_encoder_tb.sv =====
// Testbench top for the SBUS frame encoder: clock, reset, stimulus and verdict.
module sbus_frame_encoder_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sfe_pkg::*;

	localparam int CycleLimit    = 600_000;
	localparam int ResetCycles   = 5;
	localparam int DrainCycles   = 40;
	localparam int MaxGap        = 18;
	localparam int RandPhases    = 8;
	localparam int ItemsPerPhase = 27;

	logic clk = 1'b0;
	logic arst_n;
	int   cycle_count;
	bit   no_idle;       // set for phases that run both sides flat out
	int   fails;
	int   bytes_pending;

	sfe_cmd_if   cmd_ch ();
	sfe_frame_if frame_ch ();
	sfe_cfg_if   cfg_ch ();

	sbus_frame_encoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.frame  (frame_ch),
		.cfg    (cfg_ch)
	);

	sbus_frame_encoder_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd_ch),
		.frame         (frame_ch),
		.cfg           (cfg_ch),
		.fails         (fails),
		.bytes_pending (bytes_pending)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Gap before an item: none under no_idle, else back to back, short, or half the time the full range.
	function automatic int pick_gap();
		if (no_idle)
			return 0;
		case ($urandom_range(0, 3))
			0: return 0;
			1: return $urandom_range(1, 3);
			default: return $urandom_range(0, MaxGap);
		endcase
	endfunction

	// Stick values lean toward the ends of the range.
	function automatic logic [ByteW-1:0] rand_stick();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return ByteW'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [CfgDataW-1:0] rand_setting();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return '1;
			default: return CfgDataW'($urandom_range(0, 2047));
		endcase
	endfunction

	// Fixed item shapes: range ends, failsafe, ramp, alternating and walking bits.
	function automatic void directed_sticks(input int j,
		output logic [NumRaw-1:0][ByteW-1:0] raw, output logic lost);
		lost = 1'b0;
		for (int k = 0; k < NumRaw; k++) begin
			case (j)
				0: raw[k] = '0;
				1: raw[k] = '1;
				2: begin
					raw[k] = '1;
					lost   = 1'b1;
				end
				3: raw[k] = ByteW'(k * 28);
				4: raw[k] = k[0] ? 8'hAA : 8'h55;
				5: raw[k] = k[0] ? 8'h55 : 8'hAA;
				6: begin
					raw[k] = '0;
					lost   = 1'b1;
				end
				default: raw[k] = 8'h01 << (k % ByteW);
			endcase
		end
	endfunction

	// Holds valid across back-to-back items; only drops it when a gap is drawn.
	task automatic send_sticks(input logic [NumRaw-1:0][ByteW-1:0] raw, input logic lost);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid      <= 1'b1;
		cmd_ch.channel_1  <= raw[0];
		cmd_ch.channel_2  <= raw[1];
		cmd_ch.channel_3  <= raw[2];
		cmd_ch.channel_4  <= raw[3];
		cmd_ch.channel_5  <= raw[4];
		cmd_ch.channel_6  <= raw[5];
		cmd_ch.channel_7  <= raw[6];
		cmd_ch.channel_8  <= raw[7];
		cmd_ch.channel_9  <= raw[8];
		cmd_ch.channel_10 <= raw[9];
		cmd_ch.link_lost  <= lost;
		do @(posedge clk); while (!cmd_ch.ready);
	endtask

	task automatic send_directed(input int count);
		logic [NumRaw-1:0][ByteW-1:0] raw;
		logic                         lost;
		for (int j = 0; j < count; j++) begin
			directed_sticks(j, raw, lost);
			send_sticks(raw, lost);
		end
		cmd_ch.valid <= 1'b0;
	endtask

	// Wait until every predicted frame byte has come out.
	task automatic wait_drained();
		do @(posedge clk); while (bytes_pending != 0);
	endtask

	// Writes all five registers in one burst; header and footer data may carry
	// upper bits that the block must drop. Optionally hits the unmapped indexes.
	task automatic load_settings(input logic [CfgDataW-1:0] lo, input logic [CfgDataW-1:0] hi,
		input logic [CfgDataW-1:0] mid, input logic [CfgDataW-1:0] hdr,
		input logic [CfgDataW-1:0] ftr, input bit with_unused);
		logic [CfgIdxW-1:0]  idxs[$];
		logic [CfgDataW-1:0] vals[$];
		int                  gap;
		idxs.push_back(REG_MIN);
		vals.push_back(lo);
		idxs.push_back(REG_MAX);
		vals.push_back(hi);
		if (with_unused) begin
			for (int u = int'(REG_FOOTER) + 1; u < 2 ** CfgIdxW; u++) begin
				idxs.push_back(CfgIdxW'(u));
				vals.push_back(rand_setting());
			end
		end
		idxs.push_back(REG_MID);
		vals.push_back(mid);
		idxs.push_back(REG_HEADER);
		vals.push_back(hdr);
		idxs.push_back(REG_FOOTER);
		vals.push_back(ftr);
		foreach (idxs[i]) begin
			gap = pick_gap();
			if (gap > 0) begin
				cfg_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= idxs[i];
			cfg_ch.data  <= vals[i];
			do @(posedge clk); while (!cfg_ch.ready);
		end
		cfg_ch.valid <= 1'b0;
	endtask

	// Byte sink: random stall before each frame byte, then hold ready until it is taken.
	initial begin
		int gap;
		frame_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			gap = pick_gap();
			if (gap > 0) begin
				frame_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			frame_ch.ready <= 1'b1;
			do @(posedge clk); while (!frame_ch.valid);
		end
	end

	// Watchdog
	initial begin
		wait (cycle_count >= CycleLimit);
		$display("Some tests failed");
		$finish;
	end

	initial begin
		logic [NumRaw-1:0][ByteW-1:0] raw;
		logic                         lost;
		arst_n            <= 1'b0;
		cmd_ch.valid      <= 1'b0;
		cmd_ch.channel_1  <= '0;
		cmd_ch.channel_2  <= '0;
		cmd_ch.channel_3  <= '0;
		cmd_ch.channel_4  <= '0;
		cmd_ch.channel_5  <= '0;
		cmd_ch.channel_6  <= '0;
		cmd_ch.channel_7  <= '0;
		cmd_ch.channel_8  <= '0;
		cmd_ch.channel_9  <= '0;
		cmd_ch.channel_10 <= '0;
		cmd_ch.link_lost  <= 1'b0;
		cfg_ch.valid      <= 1'b0;
		cfg_ch.index      <= REG_MIN;
		cfg_ch.data       <= '0;
		repeat (ResetCycles) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset defaults: every directed shape.
		send_directed(8);

		// Inverted range (max below min), mid at zero, header all ones with spare bits set,
		// footer zero after masking.
		wait_drained();
		load_settings('1, '0, '0, 11'h7FF, 11'h400, 1'b0);
		send_directed(4);

		// Full upward range, mid at top, unmapped indexes written in between.
		wait_drained();
		load_settings('0, '1, '1, '0, 11'h0FF, 1'b1);
		send_directed(5);

		// Flat range: every stick maps to the same value.
		wait_drained();
		load_settings(11'd1000, 11'd1000, 11'd1023, 11'h0A5, 11'h75A, 1'b0);
		send_directed(3);

		// Random phases: fresh registers each time, some with no idling at all.
		for (int p = 0; p < RandPhases; p++) begin
			wait_drained();
			no_idle = (p % 3 == 1);
			load_settings(rand_setting(), rand_setting(), rand_setting(), rand_setting(),
				rand_setting(), bit'($urandom_range(0, 1)));
			for (int n = 0; n < ItemsPerPhase; n++) begin
				foreach (raw[k])
					raw[k] = rand_stick();
				lost = ($urandom_range(0, 3) == 0);
				send_sticks(raw, lost);
			end
			cmd_ch.valid <= 1'b0;
		end

		wait_drained();
		repeat (DrainCycles) @(posedge clk);
		if (fails == 0 && bytes_pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
